// ----- src/vector3_alu_defines.svh -----
// Assertion macros used by the vector3_alu checker.
`ifndef VECTOR3_ALU_DEFINES_SVH
`define VECTOR3_ALU_DEFINES_SVH

// Same-cycle implication.
`define V3ALU_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vector3_alu assertion failed");

// Next-cycle implication.
`define V3ALU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vector3_alu assertion failed");

`endif

// ----- src/v3alu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package v3alu_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   typedef logic [3:0] opcode_type;
   localparam opcode_type OP_VADD  = 4'd0;
   localparam opcode_type OP_SADD  = 4'd1;
   localparam opcode_type OP_VSUB  = 4'd2;
   localparam opcode_type OP_SSUB  = 4'd3;
   localparam opcode_type OP_SMUL  = 4'd4;
   localparam opcode_type OP_SDIV  = 4'd5;
   localparam opcode_type OP_DOT   = 4'd6;
   localparam opcode_type OP_CROSS = 4'd7;
   localparam opcode_type OP_MAG   = 4'd8;
   localparam opcode_type OP_NORM  = 4'd9;
   localparam opcode_type OP_LERP  = 4'd10;
   localparam opcode_type OP_EQUAL = 4'd11;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_DIV0 = 2'd1;
   localparam status_type ST_OVF  = 2'd2;

   typedef struct packed {
      opcode_type                   opcode;
      logic signed [DATA_WIDTH-1:0] a_x;
      logic signed [DATA_WIDTH-1:0] a_y;
      logic signed [DATA_WIDTH-1:0] a_z;
      logic signed [DATA_WIDTH-1:0] b_x;
      logic signed [DATA_WIDTH-1:0] b_y;
      logic signed [DATA_WIDTH-1:0] b_z;
      logic signed [DATA_WIDTH-1:0] scalar_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] r_x;
      logic signed [DATA_WIDTH-1:0] r_y;
      logic signed [DATA_WIDTH-1:0] r_z;
      logic signed [DATA_WIDTH-1:0] r_scalar;
      logic                         is_equal;
      status_type                   status;
   } rsp_type;

endpackage
`default_nettype wire

// ----- src/vector3_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// vector3_alu: pipelined Q16.16 3-vector arithmetic unit.
// Request channel: req_valid / req_stall / req_data (opcode, vectors a and b,
// scalar). A request is taken on a clock edge with req_valid high and
// req_stall low. Response channel: rsp_valid / rsp_stall / rsp_data (result
// vector, scalar result, is_equal, status), one response per request, in order.
// Every request, whatever its opcode, passes through the one-bit-per-stage
// square root (DATA_WIDTH stages) followed by the one-bit-per-stage
// restoring divider (2*DATA_WIDTH+2 stages) on its way to rsp_valid.
// Throughput is one request per cycle while the receiver takes responses.
// When rsp_valid is high and rsp_stall is high the whole pipeline holds,
// and req_stall is raised in the same cycle; nothing is lost or repeated.
// Synchronous reset empties the pipeline and drops rsp_valid; no clearing
// pass is needed, requests are taken in the first cycle after reset.
// Status: 0 ok, 1 division by zero (all fields zero), 2 saturated overflow.
module vector3_alu (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire v3alu_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output v3alu_pkg::rsp_type     rsp_data
);

   localparam int W    = v3alu_pkg::DATA_WIDTH;
   localparam int F    = v3alu_pkg::FRAC_BITS;
   localparam int OW   = W + 1;       // operand after one add/sub
   localparam int PW   = 2 * OW;      // product
   localparam int SW   = PW + 2;      // sum of three products
   localparam int RADW = 2 * W;       // square root radicand
   localparam int NW   = PW;          // divider numerator / quotient

   typedef struct packed {
      v3alu_pkg::opcode_type  op;
      logic [2:0][W-1:0]      a;
      logic [5:0][OW-1:0]     mx;
      logic [5:0][OW-1:0]     my;
      logic [2:0][OW-1:0]     sum;
      logic [OW-1:0]          dvs;
      logic [W-1:0]           s;
      logic                   eq;
   } prep_type;

   typedef struct packed {
      v3alu_pkg::opcode_type  op;
      logic [2:0][W-1:0]      a;
      logic [5:0][PW-1:0]     p;
      logic [2:0][OW-1:0]     sum;
      logic [OW-1:0]          dvs;
      logic [W-1:0]           s;
      logic                   eq;
   } mul_type;

   typedef struct packed {
      v3alu_pkg::opcode_type  op;
      logic [2:0][W-1:0]      a;
      logic [2:0][SW-1:0]     v;
      logic [OW-1:0]          dvs;
      logic                   eq;
   } ctx_type;

   typedef struct packed {
      ctx_type                c;
      logic [RADW-1:0]        rad;
      logic [W:0]             rem;
      logic [W-1:0]           root;
   } sq_type;

   typedef struct packed {
      ctx_type                c;
      logic                   dz;
      logic [2:0]             neg;
      logic [2:0][NW-1:0]     nq;
      logic [2:0][OW-1:0]     rem;
      logic [2:0][OW-1:0]     dm;
   } dv_type;

   function automatic logic [SW-1:0] ext_p(input logic [PW-1:0] x);
      return {{(SW-PW){x[PW-1]}}, x};
   endfunction

   function automatic logic [SW-1:0] ext_o(input logic [OW-1:0] x);
      return {{(SW-OW){x[OW-1]}}, x};
   endfunction

   function automatic logic [SW-1:0] ext_w(input logic [W-1:0] x);
      return {{(SW-W){x[W-1]}}, x};
   endfunction

   // arithmetic shift right by F, rounding toward zero
   function automatic logic [SW-1:0] shr0(input logic [SW-1:0] x);
      logic [SW-1:0] t;
      t = x + (x[SW-1] ? {{(SW-F){1'b0}}, {F{1'b1}}} : {SW{1'b0}});
      return SW'($signed(t) >>> F);
   endfunction

   // {overflow, saturated word}
   function automatic logic [W:0] sat_w(input logic [SW-1:0] x);
      logic fits;
      fits = (&x[SW-1:W-1]) || !(|x[SW-1:W-1]);
      if (fits) return {1'b0, x[W-1:0]};
      else if (x[SW-1]) return {1'b1, 1'b1, {(W-1){1'b0}}};
      else return {1'b1, 1'b0, {(W-1){1'b1}}};
   endfunction

   function automatic sq_type sq_step(input sq_type x);
      sq_type       y;
      logic [W+2:0] rp;
      logic [W+2:0] trial;
      logic [W+2:0] diff;
      logic         ge;
      y     = x;
      rp    = {x.rem, x.rad[RADW-1 -: 2]};
      trial = {1'b0, x.root, 2'b01};
      diff  = rp - trial;
      ge    = rp >= trial;
      y.rem  = ge ? diff[W:0] : rp[W:0];
      y.root = {x.root[W-2:0], ge};
      y.rad  = {x.rad[RADW-3:0], 2'b00};
      return y;
   endfunction

   function automatic dv_type dv_step(input dv_type x);
      dv_type      y;
      logic [OW:0] trial;
      logic [OW:0] diff;
      logic        ge;
      y = x;
      for (int i = 0; i < 3; i++) begin
         trial = {x.rem[i], x.nq[i][NW-1]};
         diff  = trial - {1'b0, x.dm[i]};
         ge    = trial >= {1'b0, x.dm[i]};
         y.rem[i] = ge ? diff[OW-1:0] : trial[OW-1:0];
         y.nq[i]  = {x.nq[i][NW-2:0], ge};
      end
      return y;
   endfunction

   logic       adv;
   prep_type   prep_in, prep_ff;
   mul_type    mul_in, mul_ff;
   ctx_type    cmb_in, cmb_ff;
   sq_type     scl_in;
   sq_type     sq_in [W];
   sq_type     sq_ff [W+1];
   dv_type     set_in;
   dv_type     dv_in [NW];
   dv_type     dv_ff [NW+1];
   v3alu_pkg::rsp_type rsp_in, rsp_ff;

   logic       prep_vld_ff, mul_vld_ff, cmb_vld_ff;
   logic [W:0] sq_vld_ff;
   logic [NW:0] dv_vld_ff;
   logic       rsp_valid_ff;

   logic [OW-1:0] a_e [3];
   logic [OW-1:0] b_e [3];
   logic [OW-1:0] s_e;
   logic [OW-1:0] dx;
   logic signed [PW-1:0] prod [6];

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // stage 0: operand selection, adds and lerp differences
   always_comb begin
      a_e[0] = {req_data.a_x[W-1], req_data.a_x};
      a_e[1] = {req_data.a_y[W-1], req_data.a_y};
      a_e[2] = {req_data.a_z[W-1], req_data.a_z};
      b_e[0] = {req_data.b_x[W-1], req_data.b_x};
      b_e[1] = {req_data.b_y[W-1], req_data.b_y};
      b_e[2] = {req_data.b_z[W-1], req_data.b_z};
      s_e    = {req_data.scalar_in[W-1], req_data.scalar_in};
      dx     = s_e - a_e[0];
      prep_in      = '0;
      prep_in.op   = req_data.opcode;
      prep_in.a    = {req_data.a_z, req_data.a_y, req_data.a_x};
      prep_in.s    = req_data.scalar_in;
      prep_in.eq   = (req_data.a_x == req_data.b_x) && (req_data.a_y == req_data.b_y)
                     && (req_data.a_z == req_data.b_z);
      unique case (req_data.opcode)
         v3alu_pkg::OP_VADD: begin
            for (int i = 0; i < 3; i++) prep_in.sum[i] = a_e[i] + b_e[i];
         end
         v3alu_pkg::OP_VSUB: begin
            for (int i = 0; i < 3; i++) prep_in.sum[i] = a_e[i] - b_e[i];
         end
         v3alu_pkg::OP_SADD: begin
            for (int i = 0; i < 3; i++) prep_in.sum[i] = a_e[i] + s_e;
         end
         v3alu_pkg::OP_SSUB: begin
            for (int i = 0; i < 3; i++) prep_in.sum[i] = a_e[i] - s_e;
         end
         v3alu_pkg::OP_SMUL: begin
            for (int i = 0; i < 3; i++) begin
               prep_in.mx[i] = a_e[i];
               prep_in.my[i] = s_e;
            end
         end
         v3alu_pkg::OP_SDIV: begin
            prep_in.dvs = s_e;
         end
         v3alu_pkg::OP_DOT: begin
            for (int i = 0; i < 3; i++) begin
               prep_in.mx[i] = a_e[i];
               prep_in.my[i] = b_e[i];
            end
         end
         v3alu_pkg::OP_CROSS: begin
            prep_in.mx[0] = a_e[1];  prep_in.my[0] = b_e[2];
            prep_in.mx[1] = a_e[2];  prep_in.my[1] = b_e[1];
            prep_in.mx[2] = a_e[2];  prep_in.my[2] = b_e[0];
            prep_in.mx[3] = a_e[0];  prep_in.my[3] = b_e[2];
            prep_in.mx[4] = a_e[0];  prep_in.my[4] = b_e[1];
            prep_in.mx[5] = a_e[1];  prep_in.my[5] = b_e[0];
         end
         v3alu_pkg::OP_MAG, v3alu_pkg::OP_NORM: begin
            for (int i = 0; i < 3; i++) begin
               prep_in.mx[i] = a_e[i];
               prep_in.my[i] = a_e[i];
            end
         end
         v3alu_pkg::OP_LERP: begin
            prep_in.mx[1] = dx;
            prep_in.my[1] = b_e[1] - a_e[1];
            prep_in.mx[2] = dx;
            prep_in.my[2] = b_e[2] - a_e[2];
            prep_in.dvs   = b_e[0] - a_e[0];
         end
         default: begin
         end
      endcase
   end

   // stage 1: six signed multipliers
   always_comb begin
      for (int k = 0; k < 6; k++) prod[k] = $signed(prep_ff.mx[k]) * $signed(prep_ff.my[k]);
      mul_in.op  = prep_ff.op;
      mul_in.a   = prep_ff.a;
      mul_in.sum = prep_ff.sum;
      mul_in.dvs = prep_ff.dvs;
      mul_in.s   = prep_ff.s;
      mul_in.eq  = prep_ff.eq;
      for (int k = 0; k < 6; k++) mul_in.p[k] = prod[k];
   end

   // stage 2: combine products
   always_comb begin
      cmb_in     = '0;
      cmb_in.op  = mul_ff.op;
      cmb_in.a   = mul_ff.a;
      cmb_in.dvs = mul_ff.dvs;
      cmb_in.eq  = mul_ff.eq;
      unique case (mul_ff.op)
         v3alu_pkg::OP_VADD, v3alu_pkg::OP_VSUB, v3alu_pkg::OP_SADD, v3alu_pkg::OP_SSUB: begin
            for (int i = 0; i < 3; i++) cmb_in.v[i] = ext_o(mul_ff.sum[i]);
         end
         v3alu_pkg::OP_SMUL: begin
            for (int i = 0; i < 3; i++) cmb_in.v[i] = ext_p(mul_ff.p[i]);
         end
         v3alu_pkg::OP_DOT, v3alu_pkg::OP_MAG, v3alu_pkg::OP_NORM: begin
            cmb_in.v[0] = ext_p(mul_ff.p[0]) + ext_p(mul_ff.p[1]) + ext_p(mul_ff.p[2]);
         end
         v3alu_pkg::OP_CROSS: begin
            cmb_in.v[0] = ext_p(mul_ff.p[0]) - ext_p(mul_ff.p[1]);
            cmb_in.v[1] = ext_p(mul_ff.p[2]) - ext_p(mul_ff.p[3]);
            cmb_in.v[2] = ext_p(mul_ff.p[4]) - ext_p(mul_ff.p[5]);
         end
         v3alu_pkg::OP_LERP: begin
            cmb_in.v[0] = ext_w(mul_ff.s);
            cmb_in.v[1] = ext_p(mul_ff.p[1]);
            cmb_in.v[2] = ext_p(mul_ff.p[2]);
         end
         default: begin
         end
      endcase
   end

   // stage 3: fixed-point rescale, square root setup
   always_comb begin
      scl_in      = '0;
      scl_in.c    = cmb_ff;
      scl_in.rad  = cmb_ff.v[0][RADW-1:0];
      if (cmb_ff.op == v3alu_pkg::OP_SMUL || cmb_ff.op == v3alu_pkg::OP_DOT
          || cmb_ff.op == v3alu_pkg::OP_CROSS) begin
         for (int i = 0; i < 3; i++) scl_in.c.v[i] = shr0(cmb_ff.v[i]);
      end
   end

   always_comb begin
      for (int k = 0; k < W; k++) sq_in[k] = sq_step(sq_ff[k]);
   end

   // divider setup, root is final here
   logic [OW-1:0] dvs_mag;
   logic [W-1:0]  a_mag [3];
   logic [SW-1:0] v_mag [3];
   logic          dvs_neg;
   sq_type        sq_last;

   always_comb begin
      sq_last = sq_ff[W];
      dvs_neg = sq_last.c.dvs[OW-1];
      dvs_mag = dvs_neg ? -sq_last.c.dvs : sq_last.c.dvs;
      for (int i = 0; i < 3; i++) begin
         a_mag[i] = sq_last.c.a[i][W-1] ? -sq_last.c.a[i] : sq_last.c.a[i];
         v_mag[i] = sq_last.c.v[i][SW-1] ? -sq_last.c.v[i] : sq_last.c.v[i];
      end
      set_in   = '0;
      set_in.c = sq_last.c;
      unique case (sq_last.c.op)
         v3alu_pkg::OP_MAG: begin
            set_in.c.v[0] = {{(SW-W){1'b0}}, sq_last.root};
         end
         v3alu_pkg::OP_SDIV: begin
            set_in.dz = (sq_last.c.dvs == '0);
            for (int i = 0; i < 3; i++) begin
               set_in.nq[i]  = {{(NW-W){1'b0}}, a_mag[i]} << F;
               set_in.dm[i]  = dvs_mag;
               set_in.neg[i] = sq_last.c.a[i][W-1] ^ dvs_neg;
            end
         end
         v3alu_pkg::OP_NORM: begin
            set_in.dz = (sq_last.root == '0);
            for (int i = 0; i < 3; i++) begin
               set_in.nq[i]  = {{(NW-W){1'b0}}, a_mag[i]} << F;
               set_in.dm[i]  = {1'b0, sq_last.root};
               set_in.neg[i] = sq_last.c.a[i][W-1];
            end
         end
         v3alu_pkg::OP_LERP: begin
            set_in.dz = (sq_last.c.dvs == '0);
            for (int i = 1; i < 3; i++) begin
               set_in.nq[i]  = v_mag[i][NW-1:0];
               set_in.dm[i]  = dvs_mag;
               set_in.neg[i] = sq_last.c.v[i][SW-1] ^ dvs_neg;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < NW; k++) dv_in[k] = dv_step(dv_ff[k]);
   end

   // final: sign, lerp offset, saturation, status
   dv_type        dv_last;
   logic [SW-1:0] qs [3];
   logic [SW-1:0] val [3];
   logic [W:0]    sat_r [3];
   logic          lane_div [3];
   logic          ovf;

   always_comb begin
      dv_last = dv_ff[NW];
      for (int i = 0; i < 3; i++) begin
         qs[i] = dv_last.neg[i] ? -{{(SW-NW){1'b0}}, dv_last.nq[i]}
                                :  {{(SW-NW){1'b0}}, dv_last.nq[i]};
         lane_div[i] = (dv_last.c.op == v3alu_pkg::OP_SDIV)
                    || (dv_last.c.op == v3alu_pkg::OP_NORM)
                    || (dv_last.c.op == v3alu_pkg::OP_LERP && i != 0);
         if (!lane_div[i]) val[i] = dv_last.c.v[i];
         else if (dv_last.c.op == v3alu_pkg::OP_LERP) val[i] = qs[i] + ext_w(dv_last.c.a[i]);
         else val[i] = qs[i];
         sat_r[i] = sat_w(val[i]);
      end
      rsp_in = '0;
      ovf    = 1'b0;
      unique case (dv_last.c.op)
         v3alu_pkg::OP_VADD, v3alu_pkg::OP_SADD, v3alu_pkg::OP_VSUB, v3alu_pkg::OP_SSUB,
         v3alu_pkg::OP_SMUL, v3alu_pkg::OP_SDIV, v3alu_pkg::OP_CROSS, v3alu_pkg::OP_NORM,
         v3alu_pkg::OP_LERP: begin
            rsp_in.r_x = sat_r[0][W-1:0];
            rsp_in.r_y = sat_r[1][W-1:0];
            rsp_in.r_z = sat_r[2][W-1:0];
            ovf = sat_r[0][W] | sat_r[1][W] | sat_r[2][W];
         end
         v3alu_pkg::OP_DOT, v3alu_pkg::OP_MAG: begin
            rsp_in.r_scalar = sat_r[0][W-1:0];
            ovf = sat_r[0][W];
         end
         v3alu_pkg::OP_EQUAL: begin
            rsp_in.is_equal = dv_last.c.eq;
         end
         default: begin
         end
      endcase
      if (dv_last.dz) begin
         rsp_in        = '0;
         rsp_in.status = v3alu_pkg::ST_DIV0;
      end else if (ovf) begin
         rsp_in.status = v3alu_pkg::ST_OVF;
      end else begin
         rsp_in.status = v3alu_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_vld_ff  <= 1'b0;
         mul_vld_ff   <= 1'b0;
         cmb_vld_ff   <= 1'b0;
         sq_vld_ff    <= '0;
         dv_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         prep_vld_ff  <= req_valid;
         mul_vld_ff   <= prep_vld_ff;
         cmb_vld_ff   <= mul_vld_ff;
         sq_vld_ff    <= {sq_vld_ff[W-1:0], cmb_vld_ff};
         dv_vld_ff    <= {dv_vld_ff[NW-1:0], sq_vld_ff[W]};
         rsp_valid_ff <= dv_vld_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prep_ff  <= prep_in;
         mul_ff   <= mul_in;
         cmb_ff   <= cmb_in;
         sq_ff[0] <= scl_in;
         for (int k = 0; k < W; k++) sq_ff[k+1] <= sq_in[k];
         dv_ff[0] <= set_in;
         for (int k = 0; k < NW; k++) dv_ff[k+1] <= dv_in[k];
         rsp_ff   <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/v3alu_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "vector3_alu_defines.svh"
module v3alu_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire v3alu_pkg::rsp_type rsp_data
);

   `V3ALU_ASSERT(a_div0_zero, clock, reset, rsp_valid && rsp_data.status == v3alu_pkg::ST_DIV0, rsp_data.r_x == '0 && rsp_data.r_y == '0 && rsp_data.r_z == '0 && rsp_data.r_scalar == '0 && !rsp_data.is_equal)

   `V3ALU_ASSERT(a_equal_clean, clock, reset, rsp_valid && rsp_data.is_equal, rsp_data.status == v3alu_pkg::ST_OK && rsp_data.r_x == '0 && rsp_data.r_scalar == '0)

   `V3ALU_ASSERT(a_backpressure, clock, reset, rsp_valid && rsp_stall, req_stall)

   `V3ALU_ASSERT(a_empty_accepts, clock, reset, !rsp_valid, !req_stall)

   `V3ALU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind vector3_alu v3alu_checker u_v3alu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ----- sim/vector3_alu_tb.sv -----
`timescale 1ns / 1ps
module vector3_alu_tb;
   import v3alu_pkg::*;

   typedef logic signed [191:0] wide_type;

   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          DRAIN_CYCLES  = 120;
   localparam opcode_type  OP_UNUSED_LO  = OP_EQUAL + 4'd1;
   localparam opcode_type  OP_UNUSED_HI  = 4'hf;
   localparam logic [31:0] Q_MAX         = 32'h7fffffff;
   localparam logic [31:0] Q_MIN         = 32'h80000000;
   localparam logic [31:0] Q_ONE         = 32'h00010000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type    pending_results[$];
   opcode_type pending_ops[$];
   int         cycle_count;
   int         mismatches;
   int         requests_sent;
   int         results_checked;
   int         div0_seen;
   int         ovf_seen;
   int         equal_seen;
   int         hold_left;
   bit         calm;

   vector3_alu i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------- fixed-point predictor ----------------

   // {overflow, value}
   function automatic logic [32:0] clamp_q(wide_type v);
      wide_type hi;
      wide_type lo;
      hi = $signed(Q_MAX);
      lo = $signed(Q_MIN);
      if (v > hi) begin
         return {1'b1, Q_MAX};
      end
      if (v < lo) begin
         return {1'b1, Q_MIN};
      end
      return {1'b0, v[31:0]};
   endfunction

   // drop fraction bits, rounding toward zero
   function automatic wide_type drop_frac(wide_type v);
      if (v < 0) begin
         return -((-v) >>> FRAC_BITS);
      end
      return v >>> FRAC_BITS;
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [127:0] n);
      logic [127:0] root;
      logic [127:0] cand;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = root | (128'd1 << b);
         if (cand * cand <= n) begin
            root = cand;
         end
      end
      return root[63:0];
   endfunction

   function automatic rsp_type predict_result(req_type q);
      wide_type          av[3];
      wide_type          bv[3];
      wide_type          sc;
      wide_type          acc;
      wide_type          den;
      wide_type          mw;
      logic [32:0]       cv;
      logic signed [31:0] rv[3];
      logic signed [31:0] rs;
      logic [63:0]       m;
      bit                ovf;
      bit                dz;
      bit                eq;
      rsp_type           r;
      av[0] = q.a_x; av[1] = q.a_y; av[2] = q.a_z;
      bv[0] = q.b_x; bv[1] = q.b_y; bv[2] = q.b_z;
      sc = q.scalar_in;
      rv[0] = '0; rv[1] = '0; rv[2] = '0; rs = '0;
      ovf = 1'b0; dz = 1'b0; eq = 1'b0;
      case (q.opcode)
         OP_VADD, OP_VSUB, OP_SADD, OP_SSUB, OP_SMUL: begin
            for (int i = 0; i < 3; i++) begin
               case (q.opcode)
                  OP_VADD: acc = av[i] + bv[i];
                  OP_VSUB: acc = av[i] - bv[i];
                  OP_SADD: acc = av[i] + sc;
                  OP_SSUB: acc = av[i] - sc;
                  default: acc = drop_frac(av[i] * sc);
               endcase
               cv = clamp_q(acc);
               ovf |= cv[32];
               rv[i] = cv[31:0];
            end
         end
         OP_SDIV: begin
            if (sc == 0) begin
               dz = 1'b1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  cv = clamp_q((av[i] <<< FRAC_BITS) / sc);
                  ovf |= cv[32];
                  rv[i] = cv[31:0];
               end
            end
         end
         OP_DOT: begin
            cv = clamp_q(drop_frac(av[0] * bv[0] + av[1] * bv[1] + av[2] * bv[2]));
            ovf |= cv[32];
            rs = cv[31:0];
         end
         OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               cv = clamp_q(drop_frac(av[(i + 1) % 3] * bv[(i + 2) % 3]
                                      - av[(i + 2) % 3] * bv[(i + 1) % 3]));
               ovf |= cv[32];
               rv[i] = cv[31:0];
            end
         end
         OP_MAG, OP_NORM: begin
            acc = av[0] * av[0] + av[1] * av[1] + av[2] * av[2];
            m = floor_sqrt(acc[127:0]);
            mw = {128'd0, m};
            if (q.opcode == OP_MAG) begin
               cv = clamp_q(mw);
               ovf |= cv[32];
               rs = cv[31:0];
            end else if (m == 0) begin
               dz = 1'b1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  cv = clamp_q((av[i] <<< FRAC_BITS) / mw);
                  ovf |= cv[32];
                  rv[i] = cv[31:0];
               end
            end
         end
         OP_LERP: begin
            den = bv[0] - av[0];
            if (den == 0) begin
               dz = 1'b1;
            end else begin
               rv[0] = q.scalar_in;
               for (int i = 1; i < 3; i++) begin
                  cv = clamp_q((sc - av[0]) * (bv[i] - av[i]) / den + av[i]);
                  ovf |= cv[32];
                  rv[i] = cv[31:0];
               end
            end
         end
         OP_EQUAL: eq = (av[0] == bv[0]) && (av[1] == bv[1]) && (av[2] == bv[2]);
         default: ;
      endcase
      r = '0;
      if (dz) begin
         r.status = ST_DIV0;
      end else begin
         r.r_x = rv[0];
         r.r_y = rv[1];
         r.r_z = rv[2];
         r.r_scalar = rs;
         r.is_equal = eq;
         r.status = ovf ? ST_OVF : ST_OK;
      end
      return r;
   endfunction

   // ---------------- request side ----------------

   task automatic send_request(req_type q);
      if (!calm && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_results.push_back(predict_result(q));
      pending_ops.push_back(q.opcode);
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0, 1: return $urandom;
         2: return 32'($urandom_range(32'h001fffff)) - 32'h00100000;
         3: return 32'($urandom_range(32'h3ffffff)) - 32'h2000000;
         4: begin
            case ($urandom_range(5))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return '0;
               3: return Q_ONE;
               4: return -Q_ONE;
               default: return 32'hffffffff;
            endcase
         end
         default: return $signed(32'($urandom_range(16'hffff))) >>> 0;
      endcase
   endfunction

   function automatic req_type random_request();
      req_type q;
      q.opcode    = $urandom_range(99) < 90 ? opcode_type'($urandom_range(OP_EQUAL))
                                            : opcode_type'($urandom_range(OP_UNUSED_HI,
                                                                          OP_UNUSED_LO));
      q.a_x       = pick_value();
      q.a_y       = pick_value();
      q.a_z       = pick_value();
      q.b_x       = pick_value();
      q.b_y       = pick_value();
      q.b_z       = pick_value();
      q.scalar_in = pick_value();
      case ($urandom_range(9))
         0: begin
            q.b_x = q.a_x; q.b_y = q.a_y; q.b_z = q.a_z;
         end
         1: q.scalar_in = '0;
         2: begin
            q.a_x = '0; q.a_y = '0; q.a_z = '0;
         end
         3: q.b_x = q.a_x;
         default: ;
      endcase
      return q;
   endfunction

   function automatic req_type make_request(opcode_type op, logic [31:0] ax, logic [31:0] ay,
                                            logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                                            logic [31:0] bz, logic [31:0] sc);
      req_type q;
      q = {op, ax, ay, az, bx, by, bz, sc};
      return q;
   endfunction

   // ---------------- response side ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 18);
      end
   end

   always @(posedge clock) begin
      rsp_type    want;
      opcode_type op;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result at cycle %0d: %p", cycle_count, rsp_data);
            end
         end else begin
            want = pending_results.pop_front();
            op   = pending_ops.pop_front();
            results_checked++;
            if (rsp_data.status == ST_DIV0) div0_seen++;
            if (rsp_data.status == ST_OVF) ovf_seen++;
            if (rsp_data.is_equal) equal_seen++;
            if (rsp_data.r_x !== want.r_x || rsp_data.r_y !== want.r_y ||
                rsp_data.r_z !== want.r_z || rsp_data.r_scalar !== want.r_scalar ||
                rsp_data.is_equal !== want.is_equal || rsp_data.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch op %0d cycle %0d", op, cycle_count);
                  $display("  expected x %h y %h z %h s %h eq %b st %0d", want.r_x, want.r_y,
                           want.r_z, want.r_scalar, want.is_equal, want.status);
                  $display("  actual   x %h y %h z %h s %h eq %b st %0d", rsp_data.r_x,
                           rsp_data.r_y, rsp_data.r_z, rsp_data.r_scalar, rsp_data.is_equal,
                           rsp_data.status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_results.size());
         $display("FAIL");
         $finish;
      end
   end

   // ---------------- tests ----------------

   task automatic test_directed();
      send_request(make_request(OP_VADD, Q_MAX, Q_MIN, 1, Q_MAX, Q_MIN, 2, 0));
      send_request(make_request(OP_VSUB, Q_MIN, Q_MAX, 5, Q_MAX, Q_MIN, 3, 0));
      send_request(make_request(OP_SADD, Q_MAX, 0, Q_MIN, 0, 0, 0, Q_ONE));
      send_request(make_request(OP_SSUB, Q_MIN, 0, Q_MAX, 0, 0, 0, Q_ONE));
      send_request(make_request(OP_SMUL, Q_MAX, Q_MIN, -Q_ONE, 0, 0, 0, Q_MIN));
      send_request(make_request(OP_SMUL, 3 * Q_ONE, -Q_ONE, 32'h8000, 0, 0, 0, 32'h18000));
      send_request(make_request(OP_SDIV, Q_ONE, Q_MAX, Q_MIN, 0, 0, 0, 0));
      send_request(make_request(OP_SDIV, Q_MAX, Q_MIN, 7 * Q_ONE, 0, 0, 0, -(2 * Q_ONE)));
      send_request(make_request(OP_SDIV, Q_MIN, 1, -1, 0, 0, 0, 1));
      send_request(make_request(OP_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0));
      send_request(make_request(OP_DOT, Q_ONE, 2 * Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0));
      send_request(make_request(OP_CROSS, Q_ONE, 0, 0, 0, Q_ONE, 0, 0));
      send_request(make_request(OP_CROSS, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0));
      send_request(make_request(OP_MAG, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(OP_MAG, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0));
      send_request(make_request(OP_NORM, 0, 0, 0, 1, 2, 3, 0));
      send_request(make_request(OP_NORM, 3 * Q_ONE, 4 * Q_ONE, 0, 0, 0, 0, 0));
      send_request(make_request(OP_NORM, 1, 0, 0, 0, 0, 0, 0));
      send_request(make_request(OP_LERP, Q_ONE, 2, 3, Q_ONE, 5, 6, Q_MAX));
      send_request(make_request(OP_LERP, 0, 0, Q_ONE, 2 * Q_ONE, 4 * Q_ONE, 0, Q_ONE));
      send_request(make_request(OP_LERP, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX));
      send_request(make_request(OP_EQUAL, 1, 2, 3, 1, 2, 3, 0));
      send_request(make_request(OP_EQUAL, 1, 2, 3, 1, 2, 4, 0));
      send_request(make_request(OP_UNUSED_LO, Q_MAX, 1, 2, 3, 4, 5, 6));
      send_request(make_request(OP_UNUSED_HI, Q_MIN, 1, 2, 3, 4, 5, 0));
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         send_request(random_request());
      end
   endtask

   // long receiver hold so the pipeline fills and pushes back on requests
   task automatic test_backpressure();
      hold_left = 400;
      test_random(150);
      wait_idle();
   endtask

   task automatic test_full_rate();
      calm = 1'b1;
      test_random(100);
      calm = 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      cycle_count   = 0;
      mismatches    = 0;
      requests_sent = 0;
      results_checked = 0;
      div0_seen     = 0;
      ovf_seen      = 0;
      equal_seen    = 0;
      hold_left     = 0;
      calm          = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      wait_idle();
      test_random(300);
      test_full_rate();
      test_backpressure();
      test_random(150);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests, %0d results checked, %0d mismatches", requests_sent,
               results_checked, mismatches);
      $display("divide-by-zero %0d, saturated %0d, equal %0d, incl. stall and full-rate phases",
               div0_seen, ovf_seen, equal_seen);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- vector3_alu.f -----
+incdir+src
src/v3alu_pkg.sv
src/vector3_alu.sv
src/v3alu_checker.sv
sim/vector3_alu_tb.sv
